### hdl/sara_pkg.sv
// Shared types and constants for the summed-area range-sum core.
// Used by sara_seq and summed_area_range_sum_core; no dependencies.
package sara_pkg;

  localparam int unsigned SUM_W   = 32;
  localparam int unsigned RUN_W   = 24;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned VALUE_W = 16;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_QUERY,
    ST_Q_LAST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic [IDX_W-1:0]          top_row;
    logic [IDX_W-1:0]          left_col;
    logic [IDX_W-1:0]          bottom_row;
    logic [IDX_W-1:0]          right_col;
  } in_word_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [1:0]              status;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0] row_cnt;
    logic [CNT_W-1:0] col_cnt;
    logic             restart;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

endpackage

### hdl/sara_mem.sv
// Single-port synchronous table memory with a registered read.
// No dependencies.
module sara_mem #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = 16,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sara_seq.sv
// Sequencer for loads and rectangle queries: load counters, running row sum,
// corner reads and accumulation. Depends on sara_pkg; drives the sara_mem port.
module sara_seq #(
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned ROW_W      = 8,
  parameter int unsigned COL_W      = 8,
  parameter int unsigned ADDR_W     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sara_pkg::cfg_t           cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sara_pkg::in_word_t       in_word_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output sara_pkg::out_word_t      res_word_o,
  output sara_pkg::mem_ctl_t       mem_ctl_o,
  output logic [ADDR_W-1:0]        mem_addr_o,
  output logic [sara_pkg::SUM_W-1:0] mem_wdata_o,
  input  logic [sara_pkg::SUM_W-1:0] mem_rdata_i
);

  localparam int unsigned MUL_W = ADDR_W + 1;
  localparam logic [MUL_W-1:0] COLS_C = MUL_W'(MAX_COLS);
  localparam logic [32:0] ETOP33 = 33'(1) << (ELEM_WIDTH - 1);
  localparam logic [32:0] EMASK33 = (ETOP33 << 1) - 33'd1;
  localparam logic [31:0] ETOP  = ETOP33[31:0];
  localparam logic [31:0] EMASK = EMASK33[31:0];

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    logic [MUL_W-1:0] p;
    p = MUL_W'(r) * COLS_C + MUL_W'(c);
    return p[ADDR_W-1:0];
  endfunction

  sara_pkg::state_e state_q, state_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [ROW_W-1:0] load_row_q, load_row_d;
  logic [COL_W-1:0] load_col_q, load_col_d;
  logic [sara_pkg::RUN_W-1:0] run_q, run_d;
  logic             full_q, full_d;
  logic             pend_q, pend_d;
  logic             neg_q, neg_d;

  logic [sara_pkg::RUN_W-1:0] elem_q, elem_d;
  logic [ROW_W-1:0] bot_q, bot_d, t1_q, t1_d;
  logic [COL_W-1:0] right_q, right_d, l1_q, l1_d;
  logic             t_ok_q, t_ok_d, l_ok_q, l_ok_d;
  logic [sara_pkg::SUM_W-1:0] acc_q, acc_d;
  sara_pkg::out_word_t res_q, res_d;

  logic [1:0]       q_status;
  logic             rect_bad;
  logic [31:0]      raw32, elem_ext;
  logic [ROW_W-1:0] c_row;
  logic [COL_W-1:0] c_col;
  logic             c_ok;
  logic [sara_pkg::RUN_W-1:0] run_sum;
  logic [sara_pkg::SUM_W-1:0] above, entry, acc_next;
  logic             col_last, row_last;

  assign in_stall_o = (state_q != sara_pkg::ST_IDLE);

  always_comb begin
    rect_bad = (in_word_i.top_row > in_word_i.bottom_row) ||
               (in_word_i.left_col > in_word_i.right_col) ||
               ({1'b0, in_word_i.bottom_row} >= cfg_i.row_cnt) ||
               ({1'b0, in_word_i.right_col} >= cfg_i.col_cnt);
    if (!full_q) begin
      q_status = sara_pkg::STATUS_EMPTY;
    end else if (rect_bad) begin
      q_status = sara_pkg::STATUS_RANGE;
    end else begin
      q_status = sara_pkg::STATUS_DONE;
    end
    raw32    = {16'd0, in_word_i.value};
    elem_ext = ((raw32 & EMASK) ^ ETOP) - ETOP;

    c_row = cnt_q[0] ? t1_q : bot_q;
    c_col = cnt_q[1] ? l1_q : right_q;
    c_ok  = (!cnt_q[0] || t_ok_q) && (!cnt_q[1] || l_ok_q);

    run_sum  = run_q + elem_q;
    above    = (load_row_q != '0) ? mem_rdata_i : '0;
    entry    = {{(sara_pkg::SUM_W - sara_pkg::RUN_W){run_sum[sara_pkg::RUN_W-1]}}, run_sum}
               + above;
    col_last = (32'(load_col_q) + 32'd1) >= 32'(cfg_i.col_cnt);
    row_last = (32'(load_row_q) + 32'd1) >= 32'(cfg_i.row_cnt);

    if (!pend_q) begin
      acc_next = acc_q;
    end else if (neg_q) begin
      acc_next = acc_q - mem_rdata_i;
    end else begin
      acc_next = acc_q + mem_rdata_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    run_d      = run_q;
    full_d     = full_q;
    pend_d     = 1'b0;
    neg_d      = neg_q;
    elem_d     = elem_q;
    bot_d      = bot_q;
    t1_d       = t1_q;
    right_d    = right_q;
    l1_d       = l1_q;
    t_ok_d     = t_ok_q;
    l_ok_d     = l_ok_q;
    acc_d      = acc_q;
    res_d      = res_q;
    mem_ctl_o  = '0;
    mem_addr_o = addr_of(load_row_q, load_col_q);
    mem_wdata_o = entry;
    res_valid_o = 1'b0;
    res_word_o  = res_q;

    case (state_q)
      sara_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_word_i.cmd == sara_pkg::CMD_QUERY) begin
            bot_d   = ROW_W'(in_word_i.bottom_row);
            t1_d    = ROW_W'(in_word_i.top_row - 8'd1);
            right_d = COL_W'(in_word_i.right_col);
            l1_d    = COL_W'(in_word_i.left_col - 8'd1);
            t_ok_d  = (in_word_i.top_row != '0);
            l_ok_d  = (in_word_i.left_col != '0);
            acc_d   = '0;
            if (q_status == sara_pkg::STATUS_DONE) begin
              mem_ctl_o.en = 1'b1;
              mem_addr_o   = addr_of(ROW_W'(in_word_i.bottom_row),
                                     COL_W'(in_word_i.right_col));
              pend_d  = 1'b1;
              neg_d   = 1'b0;
              cnt_d   = 2'd1;
              state_d = sara_pkg::ST_QUERY;
            end else begin
              res_d.sum    = '0;
              res_d.status = q_status;
              state_d      = sara_pkg::ST_DONE;
            end
          end else begin
            elem_d = elem_ext[sara_pkg::RUN_W-1:0];
            if (load_row_q != '0) begin
              mem_ctl_o.en = 1'b1;
              mem_addr_o   = addr_of(load_row_q - ROW_W'(1), load_col_q);
            end
            state_d = sara_pkg::ST_LOAD_WR;
          end
        end
      end
      sara_pkg::ST_LOAD_WR: begin
        mem_ctl_o.en = 1'b1;
        mem_ctl_o.we = 1'b1;
        if (load_row_q == '0 && load_col_q == '0) begin
          full_d = 1'b0;
        end
        run_d      = run_sum;
        load_col_d = load_col_q + COL_W'(1);
        if (col_last) begin
          load_col_d = '0;
          run_d      = '0;
          load_row_d = load_row_q + ROW_W'(1);
          if (row_last) begin
            load_row_d = '0;
            full_d     = 1'b1;
          end
        end
        res_word_o.sum    = '0;
        res_word_o.status = sara_pkg::STATUS_DONE;
        res_valid_o       = 1'b1;
        res_d             = res_word_o;
        state_d = res_ready_i ? sara_pkg::ST_IDLE : sara_pkg::ST_DONE;
      end
      sara_pkg::ST_QUERY: begin
        acc_d = acc_next;
        if (c_ok) begin
          mem_ctl_o.en = 1'b1;
          mem_addr_o   = addr_of(c_row, c_col);
          pend_d       = 1'b1;
          neg_d        = cnt_q[0] ^ cnt_q[1];
        end
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          state_d = sara_pkg::ST_Q_LAST;
        end
      end
      sara_pkg::ST_Q_LAST: begin
        res_word_o.sum    = acc_next;
        res_word_o.status = sara_pkg::STATUS_DONE;
        res_valid_o       = 1'b1;
        res_d             = res_word_o;
        state_d = res_ready_i ? sara_pkg::ST_IDLE : sara_pkg::ST_DONE;
      end
      sara_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sara_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sara_pkg::ST_IDLE;
      end
    endcase

    if (cfg_i.restart) begin
      load_row_d = '0;
      load_col_d = '0;
      run_d      = '0;
      full_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sara_pkg::ST_IDLE;
      cnt_q      <= '0;
      load_row_q <= '0;
      load_col_q <= '0;
      run_q      <= '0;
      full_q     <= 1'b0;
      pend_q     <= 1'b0;
      neg_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      run_q      <= run_d;
      full_q     <= full_d;
      pend_q     <= pend_d;
      neg_q      <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q  <= elem_d;
    bot_q   <= bot_d;
    t1_q    <= t1_d;
    right_q <= right_d;
    l1_q    <= l1_d;
    t_ok_q  <= t_ok_d;
    l_ok_q  <= l_ok_d;
    acc_q   <= acc_d;
    res_q   <= res_d;
  end

endmodule

### hdl/summed_area_range_sum_core.sv
// Summed-area table core: loads a matrix word by word into a single-port table
// memory and answers rectangle-sum queries from up to four corner reads. A load
// reads the entry above (rows after the first), then writes back; a query reads
// the table once per existing corner, then does the final add; a query refused
// for status goes straight to its result. The single memory port serialises these
// steps. A finished result sits in an output register while the next word is taken.
// No clearing pass is needed after reset. Depends on sara_pkg, sara_seq and sara_mem.
module summed_area_range_sum_core #(
  parameter int unsigned MAX_ROWS   = 256,
  parameter int unsigned MAX_COLS   = 256,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  sara_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output sara_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [sara_pkg::CNT_W-1:0]    cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [sara_pkg::CNT_W-1:0] ROW_RST =
    sara_pkg::CNT_W'((MAX_ROWS < 256) ? MAX_ROWS : 256);
  localparam logic [sara_pkg::CNT_W-1:0] COL_RST =
    sara_pkg::CNT_W'((MAX_COLS < 256) ? MAX_COLS : 256);

  logic [sara_pkg::CNT_W-1:0] row_cnt_q, row_cnt_d, col_cnt_q, col_cnt_d;
  logic [sara_pkg::CNT_W-1:0] cfg_lo;
  sara_pkg::cfg_t      cfg;
  logic                res_valid, res_ready;
  sara_pkg::out_word_t res_word;
  sara_pkg::mem_ctl_t  mem_ctl;
  logic [ADDR_W-1:0]   mem_addr;
  logic [sara_pkg::SUM_W-1:0] mem_wdata, mem_rdata;
  logic                out_valid_q;
  sara_pkg::out_word_t out_word_q;

  // counts saturate to 1..MAX
  always_comb begin
    cfg_lo    = (cfg_data_i == '0) ? sara_pkg::CNT_W'(1) : cfg_data_i;
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (cfg_we_i) begin
      if (cfg_index_i == sara_pkg::CFG_ROW_COUNT) begin
        row_cnt_d = (32'(cfg_lo) > MAX_ROWS) ? sara_pkg::CNT_W'(MAX_ROWS) : cfg_lo;
      end else begin
        col_cnt_d = (32'(cfg_lo) > MAX_COLS) ? sara_pkg::CNT_W'(MAX_COLS) : cfg_lo;
      end
    end
    cfg.row_cnt = row_cnt_q;
    cfg.col_cnt = col_cnt_q;
    cfg.restart = cfg_we_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= ROW_RST;
      col_cnt_q <= COL_RST;
    end else begin
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
    end
  end

  sara_seq #(
    .MAX_COLS   (MAX_COLS),
    .ELEM_WIDTH (ELEM_WIDTH),
    .ROW_W      (ROW_W),
    .COL_W      (COL_W),
    .ADDR_W     (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_word_o  (res_word),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  sara_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (sara_pkg::SUM_W)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (mem_ctl.en),
    .we_i    (mem_ctl.we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted without going busy");

  a_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.we |-> (mem_ctl.en && in_stall_o))
    else $error("table write outside a load");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_o)
    else $error("result lost on handoff");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != sara_pkg::STATUS_DONE) |-> (out_word_o.sum == '0))
    else $error("refused query carries a non-zero sum");
`endif

endmodule

### tb/summed_area_range_sum_core_tb.sv
// Testbench for summed_area_range_sum_core: loads matrices, runs rectangle
// queries and count writes, and checks each result word against a local model.
// Depends on sara_pkg and the core RTL only.
module summed_area_range_sum_core_tb;

  localparam int TBL_COLS    = 256;
  localparam int QUIET_LIMIT = 3000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  sara_pkg::in_word_t         in_word_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  sara_pkg::out_word_t        out_word_o;
  logic                       cfg_we_i = 1'b0;
  logic                       cfg_index_i = sara_pkg::CFG_ROW_COUNT;
  logic [sara_pkg::CNT_W-1:0] cfg_data_i = '0;

  summed_area_range_sum_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // model state
  logic [31:0]        area_tbl [0:65535];
  int                 ld_row, ld_col, n_rows, n_cols;
  logic signed [23:0] row_acc;
  logic               tbl_full;

  sara_pkg::out_word_t pending_sums[$];
  sara_pkg::out_word_t want;
  int          n_errors;
  int          n_sent;
  int          gap_pct;
  int          stall_pct;
  int unsigned quiet_cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] corner_at(input int r, input int c);
    if (r < 0 || c < 0) return 32'd0;
    return area_tbl[r * TBL_COLS + c];
  endfunction

  function automatic sara_pkg::out_word_t predict_range_sum(input sara_pkg::in_word_t w);
    sara_pkg::out_word_t r;
    logic [31:0] above;
    int          t, l, b, rc;
    r = '0;
    t = w.top_row;
    l = w.left_col;
    b = w.bottom_row;
    rc = w.right_col;
    if (w.cmd == sara_pkg::CMD_LOAD) begin
      if (ld_row == 0 && ld_col == 0) tbl_full = 1'b0;
      row_acc = row_acc + $signed(w.value);
      above = (ld_row > 0) ? area_tbl[(ld_row - 1) * TBL_COLS + ld_col] : 32'd0;
      area_tbl[ld_row * TBL_COLS + ld_col] = {{8{row_acc[23]}}, row_acc} + above;
      ld_col++;
      if (ld_col >= n_cols) begin
        ld_col = 0;
        row_acc = '0;
        ld_row++;
        if (ld_row >= n_rows) begin
          ld_row = 0;
          tbl_full = 1'b1;
        end
      end
      r.status = sara_pkg::STATUS_DONE;
    end else if (!tbl_full) begin
      r.status = sara_pkg::STATUS_EMPTY;
    end else if (t > b || l > rc || b >= n_rows || rc >= n_cols) begin
      r.status = sara_pkg::STATUS_RANGE;
    end else begin
      r.status = sara_pkg::STATUS_DONE;
      r.sum = corner_at(b, rc) - corner_at(t - 1, rc) - corner_at(b, l - 1)
              + corner_at(t - 1, l - 1);
    end
    return r;
  endfunction

  function automatic void restart_model();
    ld_row = 0;
    ld_col = 0;
    row_acc = '0;
    tbl_full = 1'b0;
  endfunction

  function automatic void model_count_write(input logic idx,
                                            input logic [sara_pkg::CNT_W-1:0] d);
    int v;
    v = d;
    if (v < 1) v = 1;
    if (v > 256) v = 256;
    if (idx == sara_pkg::CFG_ROW_COUNT) n_rows = v;
    else n_cols = v;
    restart_model();
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sara_pkg::in_word_t load_word(input logic [15:0] v);
    sara_pkg::in_word_t w;
    w = sara_pkg::in_word_t'({$urandom, $urandom});
    w.cmd = sara_pkg::CMD_LOAD;
    w.value = v;
    return w;
  endfunction

  function automatic sara_pkg::in_word_t query_word(input int t, input int l,
                                                    input int b, input int r);
    sara_pkg::in_word_t w;
    w.cmd = sara_pkg::CMD_QUERY;
    w.value = 16'($urandom);
    w.top_row = 8'(t);
    w.left_col = 8'(l);
    w.bottom_row = 8'(b);
    w.right_col = 8'(r);
    return w;
  endfunction

  function automatic sara_pkg::in_word_t noise_query();
    return query_word($urandom_range(255), $urandom_range(255),
                      $urandom_range(255), $urandom_range(255));
  endfunction

  function automatic sara_pkg::in_word_t rect_query(input int rows, input int cols);
    int t, l;
    t = $urandom_range(rows - 1);
    l = $urandom_range(cols - 1);
    return query_word(t, l, $urandom_range(rows - 1, t), $urandom_range(cols - 1, l));
  endfunction

  task automatic send_word(input sara_pkg::in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_sums.push_back(predict_range_sum(w));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_count(input logic idx, input logic [sara_pkg::CNT_W-1:0] d);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_count_write(idx, d);
    @(negedge clk_i);
  endtask

  task automatic set_idling(input int g, input int s);
    gap_pct = g;
    stall_pct = s;
  endtask

  // default 256x256 is far from full: queries refused, loads answered
  task automatic test_empty_table();
    send_word(query_word(0, 0, 0, 0));
    send_word(load_word(16'h1234));
    send_word(query_word(5, 5, 1, 1));
  endtask

  task automatic test_small_matrix();
    write_count(sara_pkg::CFG_ROW_COUNT, 9'd2);
    write_count(sara_pkg::CFG_COL_COUNT, 9'd3);
    send_word(load_word(16'h7fff));
    send_word(load_word(16'h8000));
    send_word(load_word(16'hffff));
    send_word(query_word(0, 0, 1, 2));
    send_word(load_word(16'h0001));
    send_word(load_word(16'h0000));
    send_word(load_word(16'h5555));
    send_word(query_word(0, 0, 1, 2));
    send_word(query_word(1, 2, 1, 2));
    send_word(query_word(1, 1, 1, 2));
    send_word(query_word(0, 1, 0, 1));
    send_word(query_word(1, 0, 0, 2));
    send_word(query_word(0, 2, 1, 1));
    send_word(query_word(0, 0, 2, 2));
    send_word(query_word(0, 0, 1, 3));
    // first load of the next matrix drops the full flag
    send_word(load_word(16'haaaa));
    send_word(query_word(0, 0, 1, 2));
  endtask

  task automatic test_load_restart();
    write_count(sara_pkg::CFG_COL_COUNT, 9'd2);
    write_count(sara_pkg::CFG_ROW_COUNT, 9'd2);
    repeat (3) send_word(load_word(rand_elem()));
    write_count(sara_pkg::CFG_COL_COUNT, 9'd2);
    send_word(query_word(0, 0, 1, 1));
    repeat (4) send_word(load_word(rand_elem()));
    send_word(query_word(0, 0, 1, 1));
    send_word(query_word(1, 1, 1, 1));
  endtask

  // counts written out of range saturate; widest row and tallest column
  task automatic test_count_limits();
    set_idling(11, 11);
    write_count(sara_pkg::CFG_ROW_COUNT, 9'd0);
    write_count(sara_pkg::CFG_COL_COUNT, 9'h1ff);
    repeat (256) send_word(load_word(rand_elem()));
    send_word(query_word(0, 0, 0, 255));
    send_word(query_word(0, 255, 0, 255));
    send_word(query_word(0, 128, 0, 255));
    send_word(query_word(1, 0, 1, 255));
    write_count(sara_pkg::CFG_COL_COUNT, 9'd0);
    write_count(sara_pkg::CFG_ROW_COUNT, 9'h12c);
    repeat (256) send_word(load_word(rand_elem()));
    send_word(query_word(0, 0, 255, 0));
    send_word(query_word(255, 0, 255, 0));
    send_word(query_word(100, 0, 255, 0));
    send_word(query_word(0, 0, 255, 1));
  endtask

  task automatic test_random_traffic(input int g, input int s, input int quota);
    int start_n, rows, cols, nq;
    set_idling(g, s);
    start_n = n_sent;
    while (n_sent - start_n < quota) begin
      rows = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      cols = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      if ($urandom_range(1)) begin
        write_count(sara_pkg::CFG_ROW_COUNT, 9'(rows));
        write_count(sara_pkg::CFG_COL_COUNT, 9'(cols));
      end else begin
        write_count(sara_pkg::CFG_COL_COUNT, 9'(cols));
        write_count(sara_pkg::CFG_ROW_COUNT, 9'(rows));
      end
      repeat ($urandom_range(1, 3)) begin
        repeat (rows * cols) begin
          if ($urandom_range(9) == 0) send_word(noise_query());
          send_word(load_word(rand_elem()));
        end
        nq = $urandom_range(2, 8);
        repeat (nq) begin
          if ($urandom_range(4) == 0) send_word(noise_query());
          else send_word(rect_query(rows, cols));
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_sums.size() == 0) begin
        $error("result word with nothing pending: sum %0d status %0d",
               $signed(out_word_o.sum), out_word_o.status);
        n_errors++;
      end else begin
        want = pending_sums.pop_front();
        if (out_word_o.sum !== want.sum) begin
          $error("sum: expected %0d, got %0d", $signed(want.sum), $signed(out_word_o.sum));
          n_errors++;
        end
        if (out_word_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_word_o.status);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    n_errors = 0;
    n_sent = 0;
    quiet_cycles = 0;
    n_rows = 256;
    n_cols = 256;
    restart_model();
    set_idling(0, 0);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_table();
    test_small_matrix();
    test_load_restart();
    test_count_limits();
    test_random_traffic(0, 0, 150);
    test_random_traffic(68, 0, 150);
    test_random_traffic(0, 68, 150);
    test_random_traffic(11, 11, 150);

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (pending_sums.size() != 0) begin
      $error("%0d result words never arrived", pending_sums.size());
    end
    if (n_errors == 0 && pending_sums.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/sara_pkg.sv
hdl/sara_mem.sv
hdl/sara_seq.sv
hdl/summed_area_range_sum_core.sv
tb/summed_area_range_sum_core_tb.sv
